FILE: rtl/mlt_pkg.sv
// Shared types and constants of the MAC learning table.
`timescale 1ns / 1ps
`default_nettype none

package mlt_pkg;

    // Table geometry. BUCKETS is a power of two, so the bucket is the low bits of the hash.
    localparam int BUCKETS = 256;
    localparam int WAYS    = 4;
    localparam int ENTRIES = BUCKETS * WAYS;
    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ADDR_W  = $clog2(ENTRIES);

    localparam int AGE_W   = 20;
    localparam int TIME_W  = 32;
    localparam int KEY_W   = 60;
    localparam int PORT_W  = 8;

    localparam logic [AGE_W-1:0] AGE_RESET = 20'd300;

    // Hash multipliers for mac[47:32], mac[31:16], mac[15:0] and vlan.
    localparam logic [31:0] HC0 = 32'h0305_0000;
    localparam logic [31:0] HC1 = 32'h0000_0709;
    localparam logic [31:0] HC2 = 32'h0b0d_0000;
    localparam logic [31:0] HC3 = 32'h0000_1113;

    localparam logic [2:0] OP_LOOKUP    = 3'd0;
    localparam logic [2:0] OP_LEARN     = 3'd1;
    localparam logic [2:0] OP_TICK      = 3'd2;
    localparam logic [2:0] OP_FLUSH_PRT = 3'd3;
    localparam logic [2:0] OP_FLUSH_ALL = 3'd4;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] deadline;
    } entry_t;

endpackage

`default_nettype wire

FILE: rtl/mlt_hash.sv
// Iterative bucket hash: one shared multiply-accumulate step per key word.
`timescale 1ns / 1ps
`default_nettype none

module mlt_hash
    import mlt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [47:0]      mac,
    input  wire logic [11:0]      vlan,
    output logic                  done,
    output logic [BKT_W-1:0]      bucket
);

    logic [47:0] mac_reg;
    logic [11:0] vlan_reg;
    logic [31:0] acc_reg;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [15:0] opnd;
    logic [31:0] coef;
    logic [47:0] prod;
    logic [31:0] fold;

    always_comb
    begin
        case (step_reg)
            2'd0:    begin opnd = mac_reg[47:32];      coef = HC0; end
            2'd1:    begin opnd = mac_reg[31:16];      coef = HC1; end
            2'd2:    begin opnd = mac_reg[15:0];       coef = HC2; end
            default: begin opnd = {4'd0, vlan_reg};    coef = HC3; end
        endcase
    end

    assign prod = {32'd0, opnd} * {16'd0, coef};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mac_reg  <= mac;
            vlan_reg <= vlan;
            acc_reg  <= 32'd0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + prod[31:0];
        end
    end

    assign fold   = acc_reg ^ (acc_reg >> 12) ^ (acc_reg >> 8) ^ (acc_reg >> 4);
    assign bucket = fold[BKT_W-1:0];
    assign done   = done_reg;

endmodule

`default_nettype wire

FILE: rtl/mac_learning_table_with_aging.sv
// Top level: MAC learning table with aging, sequencer and entry memory.
// Lookup and learn hash the key, then read and check each way of the bucket in turn, then decide.
// Tick and flush port sweep the entry memory with a read state and a check state per entry; flush all
// writes one entry a cycle. One request is in work at a time.
// After reset a clearing pass over every entry empties the table before requests are taken.
// The single memory read port sets the scan rate; a finished result waits in an output register.
`timescale 1ns / 1ps
`default_nettype none

module mac_learning_table_with_aging
    import mlt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // mac[47:0], vlan[59:48], port[67:60], zero fill
    input  wire logic [2:0]  s_tuser,   // opcode[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // hit[0], found_port[8:1], evicted[9], zero fill
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [19:0] cfg_data
);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_HASH   = 9'b000000100,
        S_RD     = 9'b000001000,
        S_EV     = 9'b000010000,
        S_DECIDE = 9'b000100000,
        S_SWRD   = 9'b001000000,
        S_SWEV   = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t             state_reg;
    logic [AGE_W-1:0]   age_reg;
    logic [TIME_W-1:0]  time_now_reg;
    logic [2:0]         op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [PORT_W-1:0]  port_reg;
    logic [BKT_W-1:0]   bucket_reg;
    logic [WAY_W-1:0]   way_reg;
    logic [ADDR_W-1:0]  idx_reg;
    logic               found_reg, free_reg;
    logic [WAY_W-1:0]   fway_reg, freeway_reg, bway_reg;
    logic [PORT_W-1:0]  fport_reg;
    logic signed [TIME_W-1:0] best_reg;
    logic               res_hit_reg, res_ev_reg;
    logic [PORT_W-1:0]  res_port_reg;
    logic               out_valid_reg;
    logic [15:0]        out_data_reg;

    entry_t             mem [ENTRIES];
    entry_t             rd_data;
    logic [ADDR_W-1:0]  rd_addr;
    logic               we;
    logic [ADDR_W-1:0]  wa;
    entry_t             wd;

    logic               in_acc;
    logic               hash_done;
    logic [BKT_W-1:0]   hash_bucket;
    logic signed [TIME_W-1:0] diff;
    logic               last_way, last_idx, out_free;
    logic [WAY_W-1:0]   new_way;
    entry_t             new_entry;

    mlt_hash u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_acc && (s_tuser == OP_LOOKUP || s_tuser == OP_LEARN)),
        .mac    (s_tdata[47:0]),
        .vlan   (s_tdata[59:48]),
        .done   (hash_done),
        .bucket (hash_bucket)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign diff     = signed'(rd_data.deadline - time_now_reg);
    assign last_way = (way_reg == WAY_W'(WAYS - 1));
    assign last_idx = (idx_reg == ADDR_W'(ENTRIES - 1));
    assign out_free = !out_valid_reg || m_tready;
    assign new_way  = found_reg ? fway_reg : (free_reg ? freeway_reg : bway_reg);

    always_comb
    begin
        new_entry.valid    = 1'b1;
        new_entry.key      = key_reg;
        new_entry.port     = port_reg;
        new_entry.deadline = time_now_reg + {{(TIME_W - AGE_W){1'b0}}, age_reg};
    end

    always_comb
    begin
        if (state_reg == S_RD)
            rd_addr = {bucket_reg, way_reg};
        else
            rd_addr = idx_reg;
    end

    // Write port: clearing pass, sweep removals and learn updates.
    always_comb
    begin
        we = 1'b0;
        wa = idx_reg;
        wd = rd_data;
        wd.valid = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
            end
            S_SWEV:
            begin
                if (op_reg == OP_TICK)
                    we = rd_data.valid && diff[TIME_W-1];
                else
                    we = rd_data.valid && (rd_data.port == port_reg);
            end
            S_DECIDE:
            begin
                wa = {bucket_reg, new_way};
                wd = new_entry;
                we = (op_reg == OP_LEARN) && (found_reg || (age_reg != '0));
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rd_data <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            age_reg <= AGE_RESET;
        else if (cfg_valid)
            age_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            time_now_reg  <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    idx_reg <= idx_reg + ADDR_W'(1);
                    if (last_idx)
                        state_reg <= (op_reg == OP_FLUSH_ALL) ? S_DONE : S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        idx_reg <= '0;
                        case (s_tuser) inside
                            OP_LOOKUP, OP_LEARN: state_reg <= S_HASH;
                            OP_TICK:
                            begin
                                time_now_reg <= time_now_reg + TIME_W'(1);
                                state_reg    <= S_SWRD;
                            end
                            OP_FLUSH_PRT: state_reg <= S_SWRD;
                            OP_FLUSH_ALL: state_reg <= S_CLEAR;
                            default:      state_reg <= S_DONE;
                        endcase
                    end
                end
                S_HASH:
                begin
                    if (hash_done)
                        state_reg <= S_RD;
                end
                S_RD:     state_reg <= S_EV;
                S_EV:     state_reg <= last_way ? S_DECIDE : S_RD;
                S_DECIDE: state_reg <= S_DONE;
                S_SWRD:   state_reg <= S_SWEV;
                S_SWEV:
                begin
                    idx_reg   <= idx_reg + ADDR_W'(1);
                    state_reg <= last_idx ? S_DONE : S_SWRD;
                end
                S_DONE:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Scan and result datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_reg <= OP_LOOKUP;
        else if (in_acc)
            op_reg <= s_tuser;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            key_reg      <= {s_tdata[47:0], s_tdata[59:48]};
            port_reg     <= s_tdata[67:60];
            res_hit_reg  <= 1'b0;
            res_ev_reg   <= 1'b0;
            res_port_reg <= '0;
            found_reg    <= 1'b0;
            free_reg     <= 1'b0;
            way_reg      <= '0;
        end
        if (state_reg == S_HASH && hash_done)
            bucket_reg <= hash_bucket;
        if (state_reg == S_EV)
        begin
            way_reg <= way_reg + WAY_W'(1);
            if (rd_data.valid)
            begin
                if (!found_reg && rd_data.key == key_reg)
                begin
                    found_reg <= 1'b1;
                    fway_reg  <= way_reg;
                    fport_reg <= rd_data.port;
                end
            end
            else if (!free_reg)
            begin
                free_reg    <= 1'b1;
                freeway_reg <= way_reg;
            end
            if (way_reg == '0 || diff < best_reg)
            begin
                best_reg <= diff;
                bway_reg <= way_reg;
            end
        end
        if (state_reg == S_DECIDE)
        begin
            if (op_reg == OP_LOOKUP)
            begin
                res_hit_reg  <= found_reg;
                res_port_reg <= found_reg ? fport_reg : '0;
            end
            else
            begin
                res_ev_reg <= !found_reg && !free_reg && (age_reg != '0);
            end
        end
        if (state_reg == S_DONE && out_free)
            out_data_reg <= {6'd0, res_ev_reg, res_port_reg, res_hit_reg};
    end

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> m_tvalid)
        else $error("finished result was not presented");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_tready)
        else $error("ready stayed high while a request is in work");

    a_time_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_tuser != OP_TICK) |=> $stable(time_now_reg))
        else $error("time advanced on a request that is not a tick");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[9]))
        else $error("result carries both hit and evicted");

endmodule

`default_nettype wire
